[hdl/apr_pkg.sv]
// Shared types and constants for the addressed packet receiver.
package apr_pkg;

  localparam int unsigned RING_DEPTH_DEFAULT = 32;
  localparam int unsigned FILL_W = 5;

  localparam logic [7:0] WAKE_BYTE      = 8'h55;
  localparam logic [7:0] FOREIGN_LIMIT  = 8'h0B;
  localparam logic [7:0] BROADCAST_ADDR = 8'h00;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic       fire;
    action_t    action;
    logic [7:0] rx_byte;
    logic       err;
  } step_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } push_t;

  typedef struct packed {
    logic listening;
    logic broadcast_seen;
    logic packet_done;
    logic error_flag;
    logic out_of_sync;
  } status_t;

endpackage

[hdl/apr_if.sv]
// Channel interfaces: received transactions in, result transactions out.
interface apr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic       frame_error;
  logic       data_overrun;

  modport source (output valid, action, rx_byte, frame_error, data_overrun, input ready);
  modport sink   (input valid, action, rx_byte, frame_error, data_overrun, output ready);
endinterface

interface apr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic       listening;
  logic       broadcast_seen;
  logic       packet_done;
  logic       error_flag;
  logic       ring_overrun;
  logic       out_of_sync;
  logic [4:0] fill_count;

  modport source (output valid, read_data, read_valid, listening, broadcast_seen,
                  packet_done, error_flag, ring_overrun, out_of_sync, fill_count,
                  input ready);
  modport sink   (input valid, read_data, read_valid, listening, broadcast_seen,
                  packet_done, error_flag, ring_overrun, out_of_sync, fill_count,
                  output ready);
endinterface

[hdl/apr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module apr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/apr_deframer.sv]
// Packet deframer: wake, address, length, payload and checksum tracking.
module apr_deframer (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  apr_pkg::step_t   step,
  output apr_pkg::push_t   push,
  output apr_pkg::status_t status
);
  import apr_pkg::*;

  typedef enum logic [5:0] {
    S_WAKE  = 6'b000001,
    S_ADDR  = 6'b000010,
    S_FLEN  = 6'b000100,
    S_FLUSH = 6'b001000,
    S_LEN   = 6'b010000,
    S_BODY  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [7:0] own_address;
  logic [7:0] remaining, remaining_next;
  logic [7:0] running_sum, running_sum_next;
  logic       broadcast, broadcast_next;
  logic       done, done_next;
  logic       error, error_next;
  logic       oos, oos_next;
  logic [7:0] sum_add;

  assign sum_add = running_sum + step.rx_byte;

  always_comb begin
    state_next       = state;
    remaining_next   = remaining;
    running_sum_next = running_sum;
    broadcast_next   = broadcast;
    done_next        = done;
    error_next       = error;
    oos_next         = oos;
    push             = '0;
    if (step.fire) begin
      case (step.action)
        ACT_BYTE: begin
          case (state)
            S_WAKE: begin
              if (step.rx_byte != WAKE_BYTE) oos_next = 1'b1;
              else state_next = S_ADDR;
            end
            S_ADDR: begin
              running_sum_next = step.rx_byte;
              if (step.err) error_next = 1'b1;
              remaining_next = '0;
              if (step.rx_byte == own_address) begin
                broadcast_next = 1'b0;
              end else if (step.rx_byte == BROADCAST_ADDR) begin
                broadcast_next = 1'b1;
              end
              if (step.rx_byte == own_address || step.rx_byte == BROADCAST_ADDR) begin
                state_next = S_LEN;
              end else begin
                state_next = S_FLEN;
              end
            end
            S_FLEN: begin
              running_sum_next = sum_add;
              if (step.err) error_next = 1'b1;
              if (step.rx_byte < FOREIGN_LIMIT) begin
                oos_next       = 1'b0;
                remaining_next = step.rx_byte + 8'd1;
                state_next     = S_FLUSH;
              end else begin
                remaining_next = step.rx_byte;
                state_next     = S_WAKE;
              end
            end
            S_FLUSH: begin
              remaining_next = remaining - 8'd1;
              if (remaining == 8'd1) state_next = S_WAKE;
            end
            S_LEN: begin
              running_sum_next = sum_add;
              if (step.err) error_next = 1'b1;
              remaining_next = step.rx_byte;
              state_next     = S_BODY;
            end
            S_BODY: begin
              running_sum_next = sum_add;
              if (step.err) error_next = 1'b1;
              if (remaining == 8'd0) begin
                // checksum byte closes the packet
                done_next  = 1'b1;
                state_next = S_WAKE;
                if (sum_add != 8'd0) error_next = 1'b1;
              end else begin
                remaining_next = remaining - 8'd1;
                push.valid     = 1'b1;
                push.data      = step.rx_byte;
              end
            end
            default: state_next = S_WAKE;
          endcase
        end
        ACT_CLEAR: begin
          done_next  = 1'b0;
          error_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_WAKE;
      own_address <= 8'd1;
      remaining   <= '0;
      running_sum <= '0;
      broadcast   <= 1'b0;
      done        <= 1'b0;
      error       <= 1'b0;
      oos         <= 1'b0;
    end else begin
      state       <= state_next;
      remaining   <= remaining_next;
      running_sum <= running_sum_next;
      broadcast   <= broadcast_next;
      done        <= done_next;
      error       <= error_next;
      oos         <= oos_next;
      if (cfg_wr_en) own_address <= cfg_wr_data;
    end
  end

  assign status.listening      = (state == S_LEN) || (state == S_BODY);
  assign status.broadcast_seen = broadcast;
  assign status.packet_done    = done;
  assign status.error_flag     = error;
  assign status.out_of_sync    = oos;

endmodule

[hdl/apr_ring.sv]
// Payload ring: pointers, storage, pop read-out, fill count and overrun flag.
module apr_ring #(
  parameter int unsigned RING_DEPTH = apr_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  apr_pkg::step_t             step,
  input  apr_pkg::push_t             push,
  output logic [7:0]                 read_data,
  output logic                       read_valid,
  output logic                       ring_overrun,
  output logic [apr_pkg::FILL_W-1:0] fill_count
);
  import apr_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned FW = PW + 1;

  logic [PW-1:0] rp, wp, rp_inc, wp_inc;
  logic [FW-1:0] fill;
  logic [7:0]    ram_q;
  logic          pop_ok, ring_full;

  assign rp_inc    = (rp == PW'(RING_DEPTH - 1)) ? '0 : rp + PW'(1);
  assign wp_inc    = (wp == PW'(RING_DEPTH - 1)) ? '0 : wp + PW'(1);
  assign pop_ok    = step.fire && (step.action == ACT_POP) && (rp != wp);
  assign ring_full = (wp_inc == rp);

  apr_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push.valid),
    .waddr (wp),
    .wdata (push.data),
    .re    (adv),
    .raddr (rp),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rp           <= '0;
      wp           <= '0;
      read_valid   <= 1'b0;
      ring_overrun <= 1'b0;
    end else begin
      if (adv) read_valid <= pop_ok;
      if (push.valid) begin
        wp <= wp_inc;
        if (ring_full) begin
          rp           <= rp_inc;
          ring_overrun <= 1'b1;
        end
      end else if (pop_ok) begin
        rp <= rp_inc;
      end
      if (step.fire && step.action == ACT_CLEAR) ring_overrun <= 1'b0;
    end
  end

  assign fill = (wp >= rp) ? (FW'(wp) - FW'(rp)) : (FW'(wp) + FW'(RING_DEPTH) - FW'(rp));
  assign fill_count = FILL_W'(fill);
  assign read_data  = read_valid ? ram_q : 8'd0;

  a_push_not_empty: assert property (@(posedge clk) disable iff (rst)
    (push.valid) |=> (rp != wp))
    else $error("ring empty after a payload write");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && pop_ok))
    else $error("payload write and pop in one transaction");

  a_full_overrun: assert property (@(posedge clk) disable iff (rst)
    (push.valid && ring_full) |=> ring_overrun)
    else $error("overrun flag not set on a full ring write");

endmodule

[hdl/addressed_packet_receiver.sv]
// Top level of the addressed packet receiver.
//
//   channel  dir  handshake          carries
//   req      in   valid/ready        action, rx_byte, frame_error, data_overrun
//   rsp      out  valid/ready        pop data, status flags, fill count
//   cfg      in   cfg_wr_en (write)  own_address
//
// One transaction per cycle while rsp does not stall; a result is registered after its request
// is taken (input register, then state update with the ring read into the result register).
// The ring RAM read port is registered and holds the pop data of the result register.
// rst is synchronous: clears all control state, own_address returns to 1.
// A stalled result holds; req.ready drops only while both stages are full and rsp stalls.
module addressed_packet_receiver #(
  parameter int unsigned RING_DEPTH = apr_pkg::RING_DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  input logic       cfg_wr_en,
  input logic [7:0] cfg_wr_data,
  apr_in_if.sink    req,
  apr_out_if.source rsp
);
  import apr_pkg::*;

  logic       a_valid, b_valid, adv;
  logic [1:0] a_action;
  logic [7:0] a_byte;
  logic       a_err;
  step_t      step;
  push_t      push;
  status_t    status;

  assign adv       = !b_valid || rsp.ready;
  assign req.ready = !a_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) a_valid <= 1'b1;
      else if (adv) a_valid <= 1'b0;
      if (adv) b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      a_action <= req.action;
      a_byte   <= req.rx_byte;
      a_err    <= req.frame_error | req.data_overrun;
    end
  end

  assign step.fire    = adv && a_valid;
  assign step.action  = action_t'(a_action);
  assign step.rx_byte = a_byte;
  assign step.err     = a_err;

  apr_deframer u_deframer (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .push        (push),
    .status      (status)
  );

  apr_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .step         (step),
    .push         (push),
    .read_data    (rsp.read_data),
    .read_valid   (rsp.read_valid),
    .ring_overrun (rsp.ring_overrun),
    .fill_count   (rsp.fill_count)
  );

  assign rsp.valid          = b_valid;
  assign rsp.listening      = status.listening;
  assign rsp.broadcast_seen = status.broadcast_seen;
  assign rsp.packet_done    = status.packet_done;
  assign rsp.error_flag     = status.error_flag;
  assign rsp.out_of_sync    = status.out_of_sync;

endmodule

[tb/tb.sv]
// Self-checking testbench for addressed_packet_receiver: packet streams with a scoreboard.
`timescale 1ns / 1ps

import apr_pkg::*;

typedef struct packed {
  logic [7:0]        read_data;
  logic              read_valid;
  logic              listening;
  logic              broadcast_seen;
  logic              packet_done;
  logic              error_flag;
  logic              ring_overrun;
  logic              out_of_sync;
  logic [FILL_W-1:0] fill_count;
} rx_status_t;

class rx_scoreboard;
  logic [7:0]  own_addr;
  bit          synced;
  bit          active;
  bit [1:0]    stage;
  logic [7:0]  bytes_left;
  logic [7:0]  csum;
  logic [7:0]  ring[RING_DEPTH_DEFAULT];
  int unsigned rd_ptr;
  int unsigned wr_ptr;
  bit          f_bcast;
  bit          f_done;
  bit          f_err;
  bit          f_ovr;
  bit          f_oos;
  rx_status_t  expected_q[$];
  int unsigned n_fail;

  function new();
    own_addr = 8'd1;
    synced = 0;
    active = 0;
    stage = 0;
    bytes_left = 0;
    csum = 0;
    rd_ptr = 0;
    wr_ptr = 0;
    {f_bcast, f_done, f_err, f_ovr, f_oos} = '0;
    n_fail = 0;
  endfunction

  function void absorb(logic [7:0] b, bit err);
    if (err) f_err = 1;
    csum = csum + b;
  endfunction

  function void on_rx(logic [7:0] b, bit err);
    if (!active) begin
      if (!synced) begin
        if (b != WAKE_BYTE) f_oos = 1;
        else begin
          synced = 1;
          stage = 0;
        end
      end else if (stage == 0) begin
        csum = 0;
        absorb(b, err);
        if (b == BROADCAST_ADDR) begin
          active = 1;
          f_bcast = 1;
        end
        if (b == own_addr) begin
          active = 1;
          f_bcast = 0;
        end
        bytes_left = 0;
        stage = 1;
      end else if (stage == 1) begin
        absorb(b, err);
        if (b < FOREIGN_LIMIT) begin
          f_oos = 0;
          bytes_left = b + 8'd1;
        end else begin
          bytes_left = b;
          synced = 0;
        end
        stage = 2;
      end else begin
        // flushing a foreign packet
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 0) synced = 0;
      end
    end else if (bytes_left == 0) begin
      absorb(b, err);
      if (stage == 1) begin
        bytes_left = b;
        stage = 2;
      end else begin
        f_done = 1;
        synced = 0;
        active = 0;
        if (csum != 0) f_err = 1;
      end
    end else begin
      bytes_left = bytes_left - 8'd1;
      absorb(b, err);
      ring[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH_DEFAULT;
      if (rd_ptr == wr_ptr) begin
        rd_ptr = (rd_ptr + 1) % RING_DEPTH_DEFAULT;
        f_ovr = 1;
      end
    end
  endfunction

  function void note_input(action_t act, logic [7:0] b, bit fe, bit ov);
    rx_status_t r;
    int unsigned fill;
    r = '0;
    case (act)
      ACT_BYTE: on_rx(b, fe | ov);
      ACT_POP: begin
        if (rd_ptr != wr_ptr) begin
          r.read_data = ring[rd_ptr];
          r.read_valid = 1'b1;
          rd_ptr = (rd_ptr + 1) % RING_DEPTH_DEFAULT;
        end
      end
      ACT_CLEAR: begin
        f_done = 0;
        f_err = 0;
        f_ovr = 0;
      end
      default: ;
    endcase
    fill = (wr_ptr + RING_DEPTH_DEFAULT - rd_ptr) % RING_DEPTH_DEFAULT;
    r.listening = active;
    r.broadcast_seen = f_bcast;
    r.packet_done = f_done;
    r.error_flag = f_err;
    r.ring_overrun = f_ovr;
    r.out_of_sync = f_oos;
    r.fill_count = fill[FILL_W-1:0];
    expected_q.push_back(r);
  endfunction

  task report(string what);
    n_fail++;
    if (n_fail <= 40) $display("mismatch %0d at %0t: %s", n_fail, $time, what);
  endtask

  task check_result(rx_status_t got);
    rx_status_t want;
    if (expected_q.size() == 0) begin
      report("result with no transaction outstanding");
      return;
    end
    want = expected_q.pop_front();
    if (got.read_data !== want.read_data)
      report($sformatf("read_data %0h, want %0h", got.read_data, want.read_data));
    if (got.read_valid !== want.read_valid)
      report($sformatf("read_valid %0b, want %0b", got.read_valid, want.read_valid));
    if (got.listening !== want.listening)
      report($sformatf("listening %0b, want %0b", got.listening, want.listening));
    if (got.broadcast_seen !== want.broadcast_seen)
      report($sformatf("broadcast_seen %0b, want %0b", got.broadcast_seen,
                       want.broadcast_seen));
    if (got.packet_done !== want.packet_done)
      report($sformatf("packet_done %0b, want %0b", got.packet_done, want.packet_done));
    if (got.error_flag !== want.error_flag)
      report($sformatf("error_flag %0b, want %0b", got.error_flag, want.error_flag));
    if (got.ring_overrun !== want.ring_overrun)
      report($sformatf("ring_overrun %0b, want %0b", got.ring_overrun, want.ring_overrun));
    if (got.out_of_sync !== want.out_of_sync)
      report($sformatf("out_of_sync %0b, want %0b", got.out_of_sync, want.out_of_sync));
    if (got.fill_count !== want.fill_count)
      report($sformatf("fill_count %0d, want %0d", got.fill_count, want.fill_count));
  endtask
endclass

module tb;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  apr_in_if  req_if();
  apr_out_if rsp_if();

  rx_scoreboard sb;
  int unsigned  n_items;
  int unsigned  n_cycles;
  int unsigned  hold_left;
  bit           hold_req;
  bit           no_gaps;

  addressed_packet_receiver u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    n_cycles = 0;
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("timeout after %0d cycles", n_cycles);
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 80;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= no_gaps || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    rx_status_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.read_data = rsp_if.read_data;
      got.read_valid = rsp_if.read_valid;
      got.listening = rsp_if.listening;
      got.broadcast_seen = rsp_if.broadcast_seen;
      got.packet_done = rsp_if.packet_done;
      got.error_flag = rsp_if.error_flag;
      got.ring_overrun = rsp_if.ring_overrun;
      got.out_of_sync = rsp_if.out_of_sync;
      got.fill_count = rsp_if.fill_count;
      sb.check_result(got);
    end
  end

  task automatic send_item(input action_t act, input logic [7:0] b, input bit fe,
                           input bit ov);
    while (!no_gaps && $urandom_range(99) < 34) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.rx_byte <= b;
    req_if.frame_error <= fe;
    req_if.data_overrun <= ov;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_input(act, b, fe, ov);
    if (act != ACT_NONE) n_items++;
  endtask

  // err_at indexes the byte list (wake byte is 0); cut_at limits how many bytes go out
  task automatic send_packet(input logic [7:0] addr, input int len, input bit bad_sum,
                             input int err_at, input bit [1:0] err_kind,
                             input int pop_pct, input int cut_at);
    logic [7:0] pkt[$];
    logic [7:0] sum;
    logic [7:0] b;
    bit         e;
    pkt.delete();
    pkt.push_back(WAKE_BYTE);
    pkt.push_back(addr);
    pkt.push_back(len[7:0]);
    sum = addr + len[7:0];
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      pkt.push_back(b);
      sum = sum + b;
    end
    b = 8'd0 - sum;
    if (bad_sum) b = b + 8'($urandom_range(1, 255));
    pkt.push_back(b);
    for (int i = 0; i < pkt.size() && i < cut_at; i++) begin
      if ($urandom_range(99) < pop_pct)
        send_item(ACT_POP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      e = (i == err_at);
      send_item(ACT_BYTE, pkt[i], e & err_kind[0], e & err_kind[1]);
    end
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.own_addr = v;
  endtask

  task automatic random_traffic(input int unsigned upto);
    int         pick;
    int         len;
    int         full;
    int         cut;
    int         err_at;
    logic [7:0] addr;
    while (n_items < upto) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 6))
          send_item(ACT_POP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end else if (pick < 11) begin
        send_item(ACT_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else if (pick < 13) begin
        send_item(ACT_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 3))
          send_item(ACT_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) addr = sb.own_addr;
        else if (pick < 55) addr = BROADCAST_ADDR;
        else addr = 8'($urandom_range(255));
        pick = $urandom_range(999);
        if (pick < 800) len = $urandom_range(0, 12);
        else if (pick < 985 || !(addr == sb.own_addr || addr == BROADCAST_ADDR))
          len = $urandom_range(13, 40);
        else len = $urandom_range(1) ? 255 : $urandom_range(41, 254);
        full = len + 4;
        cut = ($urandom_range(99) < 5) ? $urandom_range(1, full - 1) : full;
        err_at = ($urandom_range(99) < 8) ? $urandom_range(0, full - 1) : -1;
        send_packet(addr, len, $urandom_range(99) < 6, err_at, 2'($urandom_range(1, 3)),
                    15, cut);
      end
    end
  endtask

  initial begin
    sb = new();
    n_items = 0;
    hold_req = 0;
    no_gaps = 0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 8'd0;
    req_if.valid <= 1'b0;
    req_if.action <= ACT_BYTE;
    req_if.rx_byte <= 8'd0;
    req_if.frame_error <= 1'b0;
    req_if.data_overrun <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, ignored action, bad wake, own/broadcast/foreign packets
    send_item(ACT_POP, 8'hFF, 1'b1, 1'b1);
    send_item(ACT_NONE, 8'h00, 1'b0, 1'b0);
    send_item(ACT_BYTE, 8'hAA, 1'b1, 1'b0);
    send_packet(8'h01, 2, 1'b1, 3, 2'b10, 0, 99);
    send_packet(BROADCAST_ADDR, 0, 1'b0, 2, 2'b01, 0, 99);
    send_packet(8'h77, 1, 1'b0, -1, 2'b00, 0, 99);
    send_packet(8'h80, 8'hFF, 1'b0, -1, 2'b00, 0, 3);
    send_item(ACT_POP, 8'h00, 1'b0, 1'b0);
    send_item(ACT_CLEAR, 8'h00, 1'b0, 1'b0);
    random_traffic(350);
    settle();

    write_own(8'h00);
    send_packet(BROADCAST_ADDR, 40, 1'b0, -1, 2'b00, 0, 99);
    hold_req = 1;
    random_traffic(650);
    settle();

    write_own(8'hFF);
    no_gaps = 1;
    random_traffic(800);
    no_gaps = 0;
    random_traffic(950);
    settle();

    write_own(8'($urandom_range(2, 254)));
    random_traffic(1300);
    settle();

    if (sb.n_fail == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

[filelist.f]
hdl/apr_pkg.sv
hdl/apr_if.sv
hdl/apr_ram.sv
hdl/apr_deframer.sv
hdl/apr_ring.sv
hdl/addressed_packet_receiver.sv
tb/tb.sv
